>>> rtl/core/sha256_pkg.sv
package sha256_pkg;

	// Eight 32-bit hash words, word 0 least significant
	typedef logic [7:0][31:0] word8_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FEED,
		ST_PAD,
		ST_ZERO,
		ST_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	// Control from the sequencer to the round unit
	typedef struct packed {
		logic       init;
		logic       load;
		logic       step;
		logic       fold;
		logic [5:0] idx;
	} rnd_ctl_t;

	localparam int BLOCK_BYTES = 64;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [31:0] PAD_WORD = 32'h8000_0000;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

>>> rtl/core/sha256_msg.sv
module sha256_msg (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [31:0] wr_data,
	input  logic [2:0]  wr_cnt,
	input  logic [5:0]  wr_pos,
	input  logic        shift,
	output logic [31:0] w
);
	import sha256_pkg::*;

	// Block buffer, byte 0 first; doubles as the rolling schedule window
	logic [7:0] blk_q [BLOCK_BYTES];

	logic [5:0] lane_off [BLOCK_BYTES];
	logic       lane_en  [BLOCK_BYTES];
	logic [7:0] lane_byte [BLOCK_BYTES];
	logic [31:0] w1, w9, w14, w_new;

	// Words of the window at fixed taps
	assign w   = {blk_q[0],  blk_q[1],  blk_q[2],  blk_q[3]};
	assign w1  = {blk_q[4],  blk_q[5],  blk_q[6],  blk_q[7]};
	assign w9  = {blk_q[36], blk_q[37], blk_q[38], blk_q[39]};
	assign w14 = {blk_q[56], blk_q[57], blk_q[58], blk_q[59]};

	// Next schedule word, pushed in at the tail
	assign w_new = ssig1(w14) + w9 + ssig0(w1) + w;

	// Byte lane selection for a write of up to four bytes at wr_pos
	always_comb begin
		for (int j = 0; j < BLOCK_BYTES; j++) begin
			lane_off[j]  = 6'(j) - wr_pos;
			lane_en[j]   = wr_en && (lane_off[j] < {3'b000, wr_cnt});
			lane_byte[j] = wr_data[8 * (3 - int'(lane_off[j][1:0])) +: 8];
		end
	end

	// Buffer update: shift one word per round, else byte writes
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int j = 0; j < BLOCK_BYTES - 4; j++) begin
				blk_q[j] <= blk_q[j + 4];
			end
			blk_q[BLOCK_BYTES - 4] <= w_new[31:24];
			blk_q[BLOCK_BYTES - 3] <= w_new[23:16];
			blk_q[BLOCK_BYTES - 2] <= w_new[15:8];
			blk_q[BLOCK_BYTES - 1] <= w_new[7:0];
		end else begin
			for (int j = 0; j < BLOCK_BYTES; j++) begin
				if (lane_en[j]) begin
					blk_q[j] <= lane_byte[j];
				end
			end
		end
	end

endmodule

>>> rtl/core/sha256_round.sv
module sha256_round (
	input  logic                clk,
	input  logic                arst_n,
	input  sha256_pkg::rnd_ctl_t ctl,
	input  logic [31:0]         w,
	output sha256_pkg::word8_t  hash
);
	import sha256_pkg::*;

	// Working variables a..h and chaining value
	logic [31:0] v_q [8];
	word8_t      h_q;

	logic [31:0] t1, t2, ch, maj;

	// One compression round
	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bsig1(v_q[4]) + ch + K_TAB[ctl.idx] + w;
	assign t2  = bsig0(v_q[0]) + maj;

	// Working variables
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Chaining value: initial constants, then folded per block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	assign hash = h_q;

endmodule

>>> rtl/core/sha256_hash_engine.sv
// SHA-256 engine for a byte stream carried as big-endian 32-bit items with
// 0 to 4 valid leading bytes (tuser, values above 4 count as 4) and tlast on
// the final item. An item passes through the accept, a step that packs
// its bytes into the block buffer and a step that closes. An item that fills
// the block adds a load, 64 rounds and a fold, and one more write when
// its bytes run past the block edge. The block is hashed by a single round
// unit at one round per cycle. On tlast the engine appends the padding and
// the 64-bit bit length, at up to four bytes per cycle, which may take one
// extra block, then presents the eight digest words in order, index 0 first,
// with tlast on the eighth. The input is not ready from the acceptance of an
// item until its work is done and any digest is taken.
module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] message_word
	input  logic [2:0]  s_axis_tuser,   // [2:0] bytes_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);
	import sha256_pkg::*;

	state_t      state_q, state_d;
	state_t      ret_q, ret_d;
	logic [31:0] feed_q, feed_d;
	logic [2:0]  left_q, left_d;
	logic        last_q, last_d;
	logic [5:0]  pos_q, pos_d;
	logic [63:0] count_q, count_d;
	logic [5:0]  round_q, round_d;
	logic [2:0]  out_idx_q, out_idx_d;

	logic        wr_en;
	logic [31:0] wr_data;
	logic [2:0]  wr_cnt;
	logic        shift;
	logic [6:0]  room;
	logic [6:0]  gap;
	logic [63:0] bits;
	logic [31:0] w;
	rnd_ctl_t    ctl;
	word8_t      hash;

	assign room = 7'(BLOCK_BYTES) - {1'b0, pos_q};
	assign gap  = (pos_q < LEN_POS) ? {1'b0, LEN_POS - pos_q} : room;
	assign bits = {count_q[60:0], 3'b000};

	// Block buffer and schedule window
	sha256_msg u_msg (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.wr_cnt  (wr_cnt),
		.wr_pos  (pos_q),
		.shift   (shift),
		.w       (w)
	);

	// Shared round unit and chaining value
	sha256_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w      (w),
		.hash   (hash)
	);

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			left_q    <= '0;
			last_q    <= 1'b0;
			pos_q     <= '0;
			count_q   <= '0;
			round_q   <= '0;
			out_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			ret_q     <= ret_d;
			left_q    <= left_d;
			last_q    <= last_d;
			pos_q     <= pos_d;
			count_q   <= count_d;
			round_q   <= round_d;
			out_idx_q <= out_idx_d;
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		feed_q <= feed_d;
	end

	// Next state and controls; a write fills the block when the position wraps
	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		feed_d    = feed_q;
		left_d    = left_q;
		last_d    = last_q;
		pos_d     = pos_q;
		count_d   = count_q;
		round_d   = round_q;
		out_idx_d = out_idx_q;
		wr_en     = 1'b0;
		wr_data   = feed_q;
		wr_cnt    = '0;
		shift     = 1'b0;
		ctl       = '0;
		ctl.idx   = round_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;

		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					feed_d  = s_axis_tdata;
					left_d  = s_axis_tuser[2] ? 3'd4 : s_axis_tuser;
					last_d  = s_axis_tlast;
					state_d = ST_FEED;
				end
			end
			ST_FEED: begin
				if (left_q == '0) begin
					state_d = last_q ? ST_PAD : ST_IDLE;
				end else begin
					wr_cnt  = ({4'b0, left_q} < room) ? left_q : room[2:0];
					wr_en   = 1'b1;
					left_d  = left_q - wr_cnt;
					feed_d  = feed_q << {wr_cnt, 3'b000};
					count_d = count_q + 64'(wr_cnt);
					pos_d   = pos_q + 6'(wr_cnt);
					if (pos_d == '0) begin
						ret_d   = ST_FEED;
						state_d = ST_LOAD;
					end
				end
			end
			ST_PAD: begin
				// Leading one bit of the padding
				wr_en   = 1'b1;
				wr_data = PAD_WORD;
				wr_cnt  = 3'd1;
				pos_d   = pos_q + 6'd1;
				if (pos_d == '0) begin
					ret_d   = ST_ZERO;
					state_d = ST_LOAD;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (pos_q == LEN_POS) begin
					state_d = ST_LEN;
				end else begin
					wr_en   = 1'b1;
					wr_data = '0;
					wr_cnt  = (gap < 7'd4) ? gap[2:0] : 3'd4;
					pos_d   = pos_q + 6'(wr_cnt);
					if (pos_d == '0) begin
						ret_d   = ST_ZERO;
						state_d = ST_LOAD;
					end
				end
			end
			ST_LEN: begin
				// High length word at byte 56, low word at byte 60
				wr_en   = 1'b1;
				wr_data = pos_q[2] ? bits[31:0] : bits[63:32];
				wr_cnt  = 3'd4;
				pos_d   = pos_q + 6'd4;
				if (pos_d == '0) begin
					ret_d   = ST_OUT;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				round_d  = '0;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				ctl.step = 1'b1;
				shift    = 1'b1;
				round_d  = round_q + 6'd1;
				if (round_q == 6'(BLOCK_BYTES - 1)) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				ctl.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					out_idx_d = out_idx_q + 3'd1;
					if (out_idx_q == 3'd7) begin
						ctl.init = 1'b1;
						count_d  = '0;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Digest output
	assign m_axis_tdata = hash[out_idx_q];
	assign m_axis_tuser = out_idx_q;
	assign m_axis_tlast = (out_idx_q == 3'd7);

	// Input and output sides are never open together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
	else $error("input ready while digest pending");

	// A fold follows only the round sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> ($past(state_q) == ST_ROUND && $past(round_q) == 6'd63))
	else $error("fold without 64 rounds");

	// Digest is shown only on a block boundary
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (pos_q == '0))
	else $error("digest with partial block");

	// Each block starts its rounds from a fresh load
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_ROUND) |-> ($past(state_q) == ST_LOAD))
	else $error("rounds entered without load");

endmodule
